FILE: sv/flc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy level controller package
// Shared constants, widths and handshake structs of the fuzzy level controller.
// ----------------------------------------------------------------------------
package flc_pkg;

  // Output grid, integer points.
  localparam int GRID_LOW  = -25;
  localparam int GRID_HIGH = 100;
  localparam int N_PTS     = GRID_HIGH - GRID_LOW + 1;

  // Q1.15 unity and Q8.8 format.
  localparam int ONE_Q15 = 32768;
  localparam int FRAC_BITS = 8;
  localparam int W_W = 16;
  localparam int LEVEL_W = 16;
  localparam int ERR_W = LEVEL_W + 2;
  localparam int MAG_W = LEVEL_W + 1;

  // Input memberships. A slope of 10.0 in Q8.8 is 2560 counts, so
  // 32768 / 2560 = 64 / 5; the triangle half width of 5.0 gives 128 / 5.
  localparam int SIDE_SPAN = 2560;
  localparam int ZERO_HALF = 1280;
  localparam int SIDE_SHIFT = 6;
  localparam int ZERO_SHIFT = 7;
  localparam int MF_BITS = 18;
  localparam int SIDE_W = 12;
  localparam int ZERO_W = 11;

  // Division by five as a reciprocal multiplication: floor(n / 5) equals
  // (n * 52429) >> 18 for every n below 2^18, which covers MF_BITS.
  localparam int RECIP_5 = 52429;
  localparam int RECIP_SHIFT = 18;
  localparam int MF_PROD_W = MF_BITS + 16;

  // Output memberships.
  localparam int CLOSED_HALF = 25;
  localparam int OPEN_SPAN = 50;
  localparam int CLO_STEP_Q = ONE_Q15 / CLOSED_HALF;
  localparam int CLO_STEP_R = ONE_Q15 % CLOSED_HALF;
  localparam int OPN_STEP_Q = ONE_Q15 / OPEN_SPAN;
  localparam int OPN_STEP_R = ONE_Q15 % OPEN_SPAN;
  localparam int CLO_N0 = (GRID_LOW < -CLOSED_HALF) ? 0 : GRID_LOW + CLOSED_HALF;
  localparam int CLO_Q0 = (CLO_N0 * ONE_Q15) / CLOSED_HALF;
  localparam int CLO_R0 = (CLO_N0 * ONE_Q15) % CLOSED_HALF;
  localparam int REM_W = 7;

  // Grid coordinate and accumulator widths.
  localparam int X_MAG = (GRID_HIGH > -GRID_LOW) ? GRID_HIGH : -GRID_LOW;
  localparam int X_W = $clog2(X_MAG + 1) + 1;
  localparam int PROD_W = W_W + X_W + 1;
  localparam longint TOP_BOUND = longint'(ONE_Q15) * N_PTS * X_MAG;
  localparam int TOPM_W = $clog2(TOP_BOUND + 1);
  localparam int TOP_W = TOPM_W + 1;
  localparam int BOT_W = $clog2(ONE_Q15 * N_PTS + 1);

  // Divider.
  localparam int NUM_W = TOPM_W + FRAC_BITS;
  localparam int DEN_W = BOT_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  // Output saturation.
  localparam int OUT_W = 16;
  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN_MAG = 32768;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_resp_t;

  typedef struct packed {
    logic           start;
    logic [W_W-1:0] cut;
    logic [W_W-1:0] pos;
  } grid_req_t;

endpackage

FILE: sv/flc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level sample channel
// Valid/ready channel that carries one measured level per beat.
// ----------------------------------------------------------------------------
interface flc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] measured_level;

  modport source (output valid, output measured_level, input ready);
  modport sink (input valid, input measured_level, output ready);
endinterface

FILE: sv/flc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aperture result channel
// Valid/ready channel that carries one valve aperture per beat.
// ----------------------------------------------------------------------------
interface flc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] aperture;

  modport source (output valid, output aperture, input ready);
  modport sink (input valid, input aperture, output ready);
endinterface

FILE: sv/fuzzy_level_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy level controller
// Mamdani controller that turns a measured tank level into a valve aperture.
// ----------------------------------------------------------------------------
// Usage:
//   The target level (unsigned Q8.8) is written through cfg_wr_en/cfg_wr_data
//   while the block is idle. Each beat on the sample channel carries one
//   measured level; each beat on the result channel carries one signed Q8.8
//   aperture, the centroid of the composed output set, rounded toward zero.
//   One sample gives exactly one result, in order.
//   Steps: a sample beat passes through the input memberships (the divisions
//   by five are reciprocal multiplications), the grid walk (one cycle per
//   output grid point plus start and pipeline drain), the 37-bit centroid
//   division in the bit-serial divider (skipped when the weight sum is
//   zero), and the load of the output register. The block takes one sample
//   at a time and is ready again once its result sits in the output
//   register.
//   Reset clears the target level to zero and empties the output register.
//   If the receiver stalls, the finished result waits in the output register
//   and a new sample is still taken; that sample's result waits in the block
//   until the register is free.
// ----------------------------------------------------------------------------
module fuzzy_level_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  flc_in_if.sink      sample,
  flc_out_if.source   result
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_MF      = 5'b00010,
    S_GRID    = 5'b00100,
    S_DIV_CTR = 5'b01000,
    S_OUT     = 5'b10000
  } state_t;

  state_t                                state;
  logic                                  kick;
  logic [flc_pkg::LEVEL_W-1:0]           target_level;
  logic [flc_pkg::MAG_W-1:0]             mag;
  logic                                  e_neg;
  logic                                  e_pos;
  logic [flc_pkg::W_W-1:0]               cut;
  logic [flc_pkg::W_W-1:0]               pos;
  logic signed [flc_pkg::OUT_W-1:0]      res;
  logic                                  out_valid;
  logic signed [flc_pkg::OUT_W-1:0]      aperture;

  logic signed [flc_pkg::ERR_W-1:0]      err;
  logic [flc_pkg::MAG_W-1:0]             err_mag;
  logic [flc_pkg::SIDE_W-1:0]            side_dist;
  logic [flc_pkg::ZERO_W-1:0]            zero_dist;
  logic [flc_pkg::MF_BITS-1:0]           side_num;
  logic [flc_pkg::MF_BITS-1:0]           zero_num;
  logic [flc_pkg::MF_PROD_W-1:0]         side_prod;
  logic [flc_pkg::MF_PROD_W-1:0]         zero_prod;
  logic [flc_pkg::W_W-1:0]               side_mf;
  logic [flc_pkg::W_W-1:0]               zero_mf;
  logic                                  top_neg;
  logic [flc_pkg::TOPM_W-1:0]            top_abs;
  logic signed [flc_pkg::OUT_W-1:0]      ctr;

  flc_pkg::div_req_t                     div_req;
  flc_pkg::div_resp_t                    div_resp;
  flc_pkg::grid_req_t                    grid_req;
  logic                                  grid_done;
  logic signed [flc_pkg::TOP_W-1:0]      grid_top;
  logic [flc_pkg::BOT_W-1:0]             grid_bot;

  assign sample.ready    = (state == S_IDLE);
  assign result.valid    = out_valid;
  assign result.aperture = aperture;

  // Error e = target - level in signed Q8.8, kept as magnitude and sign.
  assign err     = $signed({2'b00, target_level}) - $signed({2'b00, sample.measured_level});
  assign err_mag = err[flc_pkg::ERR_W-1] ? flc_pkg::MAG_W'(-err) : flc_pkg::MAG_W'(err);

  // The outer shoulder (negative or positive, whichever side the error is on)
  // saturates at 10.0; the zero triangle vanishes beyond 5.0.
  assign side_dist = (mag >= flc_pkg::MAG_W'(flc_pkg::SIDE_SPAN)) ?
                     flc_pkg::SIDE_W'(flc_pkg::SIDE_SPAN) : flc_pkg::SIDE_W'(mag);
  assign zero_dist = (mag >= flc_pkg::MAG_W'(flc_pkg::ZERO_HALF)) ? '0 :
                     flc_pkg::ZERO_W'(flc_pkg::ZERO_HALF) - flc_pkg::ZERO_W'(mag);
  assign side_num  = flc_pkg::MF_BITS'(side_dist) << flc_pkg::SIDE_SHIFT;
  assign zero_num  = flc_pkg::MF_BITS'(zero_dist) << flc_pkg::ZERO_SHIFT;

  // Both memberships are the scaled distance divided by five, truncated.
  assign side_prod = flc_pkg::MF_PROD_W'(side_num) * flc_pkg::MF_PROD_W'(flc_pkg::RECIP_5);
  assign zero_prod = flc_pkg::MF_PROD_W'(zero_num) * flc_pkg::MF_PROD_W'(flc_pkg::RECIP_5);
  assign side_mf   = side_prod[flc_pkg::RECIP_SHIFT +: flc_pkg::W_W];
  assign zero_mf   = zero_prod[flc_pkg::RECIP_SHIFT +: flc_pkg::W_W];

  // Centroid sign and magnitude; the quotient is truncated, so negating it
  // afterwards rounds toward zero.
  assign top_neg = grid_top[flc_pkg::TOP_W-1];
  assign top_abs = top_neg ? flc_pkg::TOPM_W'(-grid_top) : flc_pkg::TOPM_W'(grid_top);

  always_comb begin
    if (top_neg) begin
      if (div_resp.quo > flc_pkg::NUM_W'(flc_pkg::OUT_MIN_MAG)) begin
        ctr = flc_pkg::OUT_W'(-flc_pkg::OUT_MIN_MAG);
      end else begin
        ctr = -$signed(flc_pkg::OUT_W'(div_resp.quo));
      end
    end else begin
      if (div_resp.quo > flc_pkg::NUM_W'(flc_pkg::OUT_MAX)) begin
        ctr = flc_pkg::OUT_W'(flc_pkg::OUT_MAX);
      end else begin
        ctr = $signed(flc_pkg::OUT_W'(div_resp.quo));
      end
    end
  end

  // The divider computes the centroid magnitude (|sum(w*x)| * 256) / sum(w).
  always_comb begin
    div_req.start = kick && (state == S_DIV_CTR);
    div_req.num   = {top_abs, {flc_pkg::FRAC_BITS{1'b0}}};
    div_req.den   = grid_bot;
    div_req.iters = flc_pkg::CNT_W'(flc_pkg::NUM_W);
  end

  assign grid_req.start = kick && (state == S_GRID);
  assign grid_req.cut   = cut;
  assign grid_req.pos   = pos;

  // Sequencer: the grid walk and the centroid division are each started with a
  // one-cycle kick, and the sequencer waits for that unit's done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      kick         <= 1'b0;
      out_valid    <= 1'b0;
      target_level <= '0;
    end else begin
      kick <= 1'b0;
      if (cfg_wr_en) begin
        target_level <= cfg_wr_data;
      end
      if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            mag   <= err_mag;
            e_neg <= err[flc_pkg::ERR_W-1];
            e_pos <= !err[flc_pkg::ERR_W-1] && (err != '0);
            state <= S_MF;
          end
        end
        S_MF: begin
          // The closed set is clipped by max(negative, zero).
          cut   <= (e_neg && (side_mf > zero_mf)) ? side_mf : zero_mf;
          pos   <= e_pos ? side_mf : '0;
          kick  <= 1'b1;
          state <= S_GRID;
        end
        S_GRID: begin
          if (grid_done) begin
            if (grid_bot == '0) begin
              res   <= '0;
              state <= S_OUT;
            end else begin
              kick  <= 1'b1;
              state <= S_DIV_CTR;
            end
          end
        end
        S_DIV_CTR: begin
          if (div_resp.done) begin
            res   <= ctr;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            aperture  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  flc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  flc_grid u_grid (
    .clk  (clk),
    .rst  (rst),
    .req  (grid_req),
    .done (grid_done),
    .top  (grid_top),
    .bot  (grid_bot)
  );

`ifndef SYNTHESIS
  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_resp.busy)
    else $error("divider started while busy");

  a_div_done_owner: assert property (@(posedge clk) disable iff (rst)
    div_resp.done |-> (state == S_DIV_CTR))
    else $error("divider finished outside the centroid step");

  a_grid_done_owner: assert property (@(posedge clk) disable iff (rst)
    grid_done |-> (state == S_GRID))
    else $error("grid walk finished outside the grid step");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == S_MF))
    else $error("accepted sample did not start the membership step");
`endif

endmodule

FILE: sv/flc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divider that retires one quotient bit per cycle for a given count.
// ----------------------------------------------------------------------------
module flc_div (
  input  logic               clk,
  input  logic               rst,
  input  flc_pkg::div_req_t  req,
  output flc_pkg::div_resp_t resp
);

  logic                        busy;
  logic                        done;
  logic [flc_pkg::CNT_W-1:0]   cnt;
  logic [flc_pkg::NUM_W-1:0]   num;
  logic [flc_pkg::NUM_W-1:0]   quo;
  logic [flc_pkg::DEN_W-1:0]   rem;
  logic [flc_pkg::DEN_W-1:0]   den;
  logic [flc_pkg::DEN_W:0]     trial;
  logic                        fits;

  // The numerator is consumed from its top bit, so short divisions are left aligned.
  assign trial = {rem, num[flc_pkg::NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.iters;
        num  <= req.num;
        den  <= req.den;
        quo  <= '0;
        rem  <= '0;
      end else if (busy) begin
        num <= {num[flc_pkg::NUM_W-2:0], 1'b0};
        quo <= {quo[flc_pkg::NUM_W-2:0], fits};
        rem <= fits ? flc_pkg::DEN_W'(trial - {1'b0, den}) : flc_pkg::DEN_W'(trial);
        cnt <= cnt - 1'b1;
        if (cnt == flc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign resp.busy = busy;
  assign resp.done = done;
  assign resp.quo  = quo;

endmodule

FILE: sv/flc_grid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output grid walker
// Steps over the output grid one point per cycle and accumulates the
// weighted and plain sums of the composed output membership.
// ----------------------------------------------------------------------------
module flc_grid (
  input  logic                              clk,
  input  logic                              rst,
  input  flc_pkg::grid_req_t                req,
  output logic                              done,
  output logic signed [flc_pkg::TOP_W-1:0]  top,
  output logic        [flc_pkg::BOT_W-1:0]  bot
);

  localparam logic signed [flc_pkg::X_W-1:0] X_FIRST = flc_pkg::X_W'(flc_pkg::GRID_LOW);
  localparam logic signed [flc_pkg::X_W-1:0] X_LAST  = flc_pkg::X_W'(flc_pkg::GRID_HIGH);
  localparam logic signed [flc_pkg::X_W-1:0] X_CLO_LO = flc_pkg::X_W'(-flc_pkg::CLOSED_HALF);
  localparam logic signed [flc_pkg::X_W-1:0] X_CLO_HI = flc_pkg::X_W'(flc_pkg::CLOSED_HALF - 1);
  localparam logic signed [flc_pkg::X_W-1:0] X_OPN_HI = flc_pkg::X_W'(flc_pkg::OPEN_SPAN - 1);
  localparam logic signed [flc_pkg::X_W-1:0] X_ZERO = '0;

  logic                              running;
  logic signed [flc_pkg::X_W-1:0]    x;
  logic [flc_pkg::W_W-1:0]           clo_q;
  logic [flc_pkg::REM_W-1:0]         clo_r;
  logic [flc_pkg::W_W-1:0]           opn_q;
  logic [flc_pkg::REM_W-1:0]         opn_r;
  logic [flc_pkg::W_W-1:0]           cut;
  logic [flc_pkg::W_W-1:0]           pos;

  logic                              v1;
  logic                              l1;
  logic [flc_pkg::W_W-1:0]           w1;
  logic signed [flc_pkg::X_W-1:0]    x1;
  logic                              v2;
  logic                              l2;
  logic [flc_pkg::W_W-1:0]           w2;
  logic signed [flc_pkg::PROD_W-1:0] prod2;

  logic [flc_pkg::W_W-1:0]           clo_cut;
  logic [flc_pkg::W_W-1:0]           opn_cut;
  logic [flc_pkg::W_W-1:0]           w;
  logic                              clo_up;
  logic                              clo_dn;
  logic                              opn_up;
  logic [flc_pkg::REM_W-1:0]         clo_r_up;
  logic [flc_pkg::REM_W-1:0]         opn_r_up;

  // Clipped shapes, then their maximum.
  assign clo_cut = (cut < clo_q) ? cut : clo_q;
  assign opn_cut = (pos < opn_q) ? pos : opn_q;
  assign w       = (clo_cut > opn_cut) ? clo_cut : opn_cut;

  // The shape values are floor(n * 32768 / d), kept as quotient and remainder
  // and stepped by 32768 / d each time the distance n moves by one.
  assign clo_up = (x >= X_CLO_LO) && (x < X_ZERO);
  assign clo_dn = (x >= X_ZERO) && (x <= X_CLO_HI);
  assign opn_up = (x >= X_ZERO) && (x <= X_OPN_HI);
  assign clo_r_up = clo_r + flc_pkg::REM_W'(flc_pkg::CLO_STEP_R);
  assign opn_r_up = opn_r + flc_pkg::REM_W'(flc_pkg::OPN_STEP_R);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      done    <= 1'b0;
    end else begin
      v1   <= 1'b0;
      v2   <= v1;
      done <= v2 && l2;
      if (req.start) begin
        running <= 1'b1;
        cut     <= req.cut;
        pos     <= req.pos;
        x       <= X_FIRST;
        clo_q   <= flc_pkg::W_W'(flc_pkg::CLO_Q0);
        clo_r   <= flc_pkg::REM_W'(flc_pkg::CLO_R0);
        opn_q   <= '0;
        opn_r   <= '0;
        top     <= '0;
        bot     <= '0;
      end else if (running) begin
        v1 <= 1'b1;
        l1 <= (x == X_LAST);
        w1 <= w;
        x1 <= x;
        if (x == X_LAST) begin
          running <= 1'b0;
        end else begin
          x <= x + 1'b1;
        end
        if (clo_up) begin
          if (clo_r_up >= flc_pkg::REM_W'(flc_pkg::CLOSED_HALF)) begin
            clo_r <= clo_r_up - flc_pkg::REM_W'(flc_pkg::CLOSED_HALF);
            clo_q <= clo_q + flc_pkg::W_W'(flc_pkg::CLO_STEP_Q + 1);
          end else begin
            clo_r <= clo_r_up;
            clo_q <= clo_q + flc_pkg::W_W'(flc_pkg::CLO_STEP_Q);
          end
        end else if (clo_dn) begin
          if (clo_r < flc_pkg::REM_W'(flc_pkg::CLO_STEP_R)) begin
            clo_r <= clo_r + flc_pkg::REM_W'(flc_pkg::CLOSED_HALF - flc_pkg::CLO_STEP_R);
            clo_q <= clo_q - flc_pkg::W_W'(flc_pkg::CLO_STEP_Q + 1);
          end else begin
            clo_r <= clo_r - flc_pkg::REM_W'(flc_pkg::CLO_STEP_R);
            clo_q <= clo_q - flc_pkg::W_W'(flc_pkg::CLO_STEP_Q);
          end
        end
        if (opn_up) begin
          if (opn_r_up >= flc_pkg::REM_W'(flc_pkg::OPEN_SPAN)) begin
            opn_r <= opn_r_up - flc_pkg::REM_W'(flc_pkg::OPEN_SPAN);
            opn_q <= opn_q + flc_pkg::W_W'(flc_pkg::OPN_STEP_Q + 1);
          end else begin
            opn_r <= opn_r_up;
            opn_q <= opn_q + flc_pkg::W_W'(flc_pkg::OPN_STEP_Q);
          end
        end
      end
      if (v1) begin
        l2    <= l1;
        w2    <= w1;
        prod2 <= $signed({1'b0, w1}) * x1;
      end
      if (v2) begin
        top <= top + flc_pkg::TOP_W'(prod2);
        bot <= bot + flc_pkg::BOT_W'(w2);
      end
    end
  end

endmodule

FILE: tb/sv/fuzzy_level_controller_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy level controller testbench
// Drives measured levels into the controller under several target levels and
// idle patterns. A bit-exact centroid predictor inside a small scoreboard
// checks every aperture, in order, against the result channel.
// ----------------------------------------------------------------------------

typedef logic signed [15:0] aperture_t;

class aperture_scoreboard;
  // Q1.15 unity, and the input and output shapes in their own units.
  localparam longint ONE         = 32768;
  localparam longint ERR_SPAN    = 2560;  // 10.0 in Q8.8
  localparam longint ERR_HALF    = 1280;  // 5.0 in Q8.8
  localparam int     GRID_FIRST  = -25;
  localparam int     GRID_LAST   = 100;
  localparam int     CLOSED_HALF = 25;
  localparam int     OPEN_SPAN   = 50;
  localparam int     MAX_REPORTS = 10;

  aperture_t owed_apertures[$];
  int        errors;
  int        checked;

  function new();
    errors  = 0;
    checked = 0;
  endfunction

  // Composes the clipped output sets on the integer grid and returns their
  // centroid in signed Q8.8, rounded toward zero and saturated to 16 bits.
  function aperture_t centroid_aperture(logic [15:0] target, logic [15:0] level);
    longint err, neg, zro, pos, cut, clo, opn, gate, w, top, bot, res;
    err = longint'(target) - longint'(level);
    if (err <= -ERR_SPAN) neg = ONE;
    else if (err < 0) neg = (-err * ONE) / ERR_SPAN;
    else neg = 0;
    if (err < -ERR_HALF || err > ERR_HALF) zro = 0;
    else if (err <= 0) zro = ((err + ERR_HALF) * ONE) / ERR_HALF;
    else zro = ((ERR_HALF - err) * ONE) / ERR_HALF;
    if (err >= ERR_SPAN) pos = ONE;
    else if (err > 0) pos = (err * ONE) / ERR_SPAN;
    else pos = 0;
    cut = (neg > zro) ? neg : zro;
    top = 0;
    bot = 0;
    for (int x = GRID_FIRST; x <= GRID_LAST; x++) begin
      if (x < -CLOSED_HALF || x > CLOSED_HALF) clo = 0;
      else if (x <= 0) clo = ((x + CLOSED_HALF) * ONE) / CLOSED_HALF;
      else clo = ((CLOSED_HALF - x) * ONE) / CLOSED_HALF;
      if (x >= OPEN_SPAN) opn = ONE;
      else if (x > 0) opn = (x * ONE) / OPEN_SPAN;
      else opn = 0;
      w    = (cut < clo) ? cut : clo;
      gate = (pos < opn) ? pos : opn;
      if (gate > w) w = gate;
      top += w * x;
      bot += w;
    end
    res = 0;
    if (bot != 0) begin
      res = (top * 256) / bot;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
    end
    return res[15:0];
  endfunction

  function void note_level(logic [15:0] target, logic [15:0] level);
    aperture_t owed_one;
    owed_one       = centroid_aperture(target, level);
    owed_apertures = {owed_apertures, owed_one};
  endfunction

  function void check_aperture(aperture_t got);
    aperture_t want;
    checked++;
    if (owed_apertures.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("aperture beat %0d arrived with nothing owed: got %0d", checked, got);
      return;
    end
    want = owed_apertures.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("aperture beat %0d mismatch: expected %0d, got %0d", checked, want, got);
    end
  endfunction

  function int owed();
    return owed_apertures.size();
  endfunction
endclass

module fuzzy_level_controller_unit_tb;

  // The slowest legal gap between beats is one sample's latency plus the
  // long receiver hold-off; the watchdog allows far more.
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int HOLD_AT_BEAT = 120;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS  = 250;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  flc_in_if  level_ch();
  flc_out_if aperture_ch();

  fuzzy_level_controller_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (level_ch),
    .result      (aperture_ch)
  );

  aperture_scoreboard board;

  // Our copy of the target register, updated at the edge that writes it.
  logic [15:0] target_copy;

  // Idle percentages of the two sides, changed between phases.
  int send_idle_pct;
  int recv_idle_pct;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Writes the target register. Only called while nothing is in flight.
  task automatic write_target(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    target_copy = value;
  endtask

  // Lowers valid and waits until every owed aperture has come back. At
  // least one edge always passes, so valid never gets two updates in a step.
  task automatic wait_drained();
    level_ch.valid <= 1'b0;
    do @(posedge clk); while (board.owed() != 0);
  endtask

  // Offers one level and returns at the edge where the beat is taken. Valid
  // stays high into the next call unless that call decides to idle first.
  task automatic send_level(input logic [15:0] level);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      level_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    level_ch.valid          <= 1'b1;
    level_ch.measured_level <= level;
    do @(posedge clk); while (!(level_ch.valid && level_ch.ready));
    board.note_level(target_copy, level);
  endtask

  // Most levels sit within 12.0 of the target so that every membership
  // slope is exercised; some hug the shoulder and triangle corners, and the
  // rest span the whole 16-bit range.
  function automatic logic [15:0] pick_level(input logic [15:0] target);
    int corners[5] = '{-2560, -1280, 0, 1280, 2560};
    int r, off, lvl;
    r = $urandom_range(99);
    if (r < 20) return 16'($urandom);
    if (r < 30) off = corners[$urandom_range(4)] + int'($urandom_range(2)) - 1;
    else off = int'($urandom_range(6144)) - 3072;
    lvl = int'(target) - off;
    if (lvl < 0) lvl = 0;
    if (lvl > 65535) lvl = 65535;
    return lvl[15:0];
  endfunction

  // One random phase under one target and one idle pattern. When pause_at
  // is reached, the sender holds back until all owed apertures are back.
  task automatic run_phase(input logic [15:0] target, input int s_pct, input int r_pct,
                           input int pause_at);
    wait_drained();
    write_target(target);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == pause_at) wait_drained();
      send_level(pick_level(target));
    end
  endtask

  // Result side: checks each beat and drives ready for the next edge. Once,
  // after a fixed number of beats, it holds ready low for a long stretch so
  // the block fills up and backs up the sample channel.
  initial begin : aperture_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    aperture_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && aperture_ch.valid && aperture_ch.ready) begin
        board.check_aperture(aperture_ch.aperture);
        if (!hold_done && board.checked == HOLD_AT_BEAT) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        aperture_ch.ready <= 1'b0;
      end else begin
        aperture_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Ends the run if no beat moves on either channel for too long.
  initial begin : stall_watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (level_ch.valid && level_ch.ready) ||
          (aperture_ch.valid && aperture_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    // Errors around target 16.0 that sit on and beside each corner of the
    // shoulders and the zero triangle.
    int corner_err[15] = '{-2561, -2560, -2559, -1281, -1280, -1279, -1, 0, 1,
                           1279, 1280, 1281, 2559, 2560, 2561};
    board                   = new();
    rst                     = 1'b1;
    cfg_wr_en               = 1'b0;
    cfg_wr_data             = 16'h0000;
    level_ch.valid          = 1'b0;
    level_ch.measured_level = 16'h0000;
    target_copy             = 16'h0000;
    send_idle_pct           = 14;
    recv_idle_pct           = 79;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: corner errors, then the largest errors of both signs
    // with the target at either end of its range.
    write_target(16'h1000);
    foreach (corner_err[i]) send_level(16'(4096 - corner_err[i]));
    send_level(16'h0000);
    send_level(16'hFFFF);
    wait_drained();
    write_target(16'h0000);
    send_level(16'h0000);
    send_level(16'hFFFF);
    wait_drained();
    write_target(16'hFFFF);
    send_level(16'h0000);
    send_level(16'hFFFF);

    // Random part: mid-range and extreme targets under all three idle
    // patterns. The long receiver hold-off falls in the first phase.
    run_phase(16'($urandom_range(4096, 61439)), 14, 79, -1);
    run_phase(16'h0000, 14, 79, -1);
    run_phase(16'hFFFF, 79, 14, -1);
    run_phase(16'($urandom_range(4096, 61439)), 79, 14, 60);
    run_phase(16'($urandom_range(4096, 61439)), 0, 0, -1);
    run_phase(16'($urandom_range(0, 65535)), 0, 0, -1);

    // Let the last apertures come back, then watch for strays.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.owed() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
